>>> hdl/cscan_pkg.sv
// cscan_pkg: shared types and constants of the C-SCAN request scheduler.
// Used by every module under hdl/; depends on nothing.
package cscan_pkg;

    // Seek accumulator width and its saturation ceiling
    localparam int               SEEK_W   = 18;
    localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

    // Configuration register indexes
    localparam int         CFG_IDX_W       = 1;
    localparam logic [0:0] CFG_DISK_TRACKS = 1'b0;
    localparam logic [0:0] CFG_START_HEAD  = 1'b1;

    // Front-end sequencer phases
    typedef enum logic [1:0] {
        PH_LOAD,
        PH_ROTATE,
        PH_EMIT
    } t_phase;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> hdl/cscan_front.sv
// cscan_front: loads requests into an insertion-sorted store, splits them around the
// start head and pushes visits in C-SCAN order with their seek distance.
// Depends on cscan_pkg.
module cscan_front #(
    parameter int MAX_REQUESTS = 32,
    parameter int TRACK_BITS   = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [TRACK_BITS-1:0]       i_request_track,
    input  logic                        i_last_request,
    input  logic [TRACK_BITS:0]         i_disk_tracks,
    input  logic [TRACK_BITS-1:0]       i_start_head,
    input  cscan_pkg::t_q_status        i_q_status,
    output logic                        o_busy,
    output logic                        o_push,
    output logic [2*TRACK_BITS:0]       o_item
);
    import cscan_pkg::*;

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_ROTATE,
        OP_SHIFT
    } t_store_op;

    logic [TRACK_BITS-1:0] r_store [MAX_REQUESTS];
    logic [TRACK_BITS-1:0] n_store [MAX_REQUESTS];
    logic [TRACK_BITS-1:0] ins_val [MAX_REQUESTS];
    logic [TRACK_BITS-1:0] shf_val [MAX_REQUESTS];
    logic [TRACK_BITS-1:0] rot_val [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] gt;

    t_phase                r_phase, n_phase;
    t_store_op             store_op;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_lower, n_lower;
    logic [CNT_W-1:0]      r_remain, n_remain;
    logic [TRACK_BITS-1:0] r_head, n_head;
    logic [TRACK_BITS-1:0] r_outer, n_outer;
    logic [TRACK_BITS-1:0] r_prev, n_prev;
    logic                  r_outer_done, n_outer_done;
    logic                  r_jump_done, n_jump_done;

    logic                  store_ok;
    logic                  upper_left;
    logic [TRACK_BITS:0]   outer_full;
    logic [TRACK_BITS-1:0] outer_sat;
    logic [TRACK_BITS-1:0] e0;
    logic [TRACK_BITS-1:0] push_track;
    logic [TRACK_BITS-1:0] push_dist;
    logic [TRACK_BITS-1:0] step_dist;
    logic                  push_last;
    logic                  push_jump;
    logic                  push;

    assign e0         = r_store[0];
    assign store_ok   = (r_cnt < CNT_W'(MAX_REQUESTS));
    assign upper_left = (r_cnt != r_lower);
    assign outer_full = (i_disk_tracks == '0) ? '0 : i_disk_tracks - 1'b1;
    assign outer_sat  = outer_full[TRACK_BITS] ? '1 : outer_full[TRACK_BITS-1:0];
    assign step_dist  = (push_track > r_prev) ? push_track - r_prev : r_prev - push_track;
    assign push_dist  = push_jump ? r_outer : step_dist;

    // Candidate next values of each store slot
    genvar g;
    generate
        for (g = 0; g < MAX_REQUESTS; g++) begin : g_slot
            assign gt[g] = (CNT_W'(g) < r_cnt) && (r_store[g] > i_request_track);
            if (g > 0) begin : g_mid
                assign ins_val[g] = gt[g-1] ? r_store[g-1] :
                                    ((gt[g] || CNT_W'(g) == r_cnt) ? i_request_track
                                                                   : r_store[g]);
            end else begin : g_first
                assign ins_val[g] = (gt[g] || r_cnt == '0) ? i_request_track : r_store[g];
            end
            if (g < MAX_REQUESTS - 1) begin : g_shift
                assign shf_val[g] = r_store[g+1];
            end else begin : g_tail
                assign shf_val[g] = r_store[g];
            end
            assign rot_val[g] = (CNT_W'(g) + CNT_W'(1) == r_cnt) ? r_store[0] : shf_val[g];
        end
    endgenerate

    always_comb begin
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            case (store_op)
                OP_INSERT: n_store[i] = ins_val[i];
                OP_ROTATE: n_store[i] = rot_val[i];
                OP_SHIFT:  n_store[i] = shf_val[i];
                default:   n_store[i] = r_store[i];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            r_store[i] <= n_store[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LOAD;
            r_cnt        <= '0;
            r_lower      <= '0;
            r_remain     <= '0;
            r_outer_done <= 1'b0;
            r_jump_done  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_cnt        <= n_cnt;
            r_lower      <= n_lower;
            r_remain     <= n_remain;
            r_outer_done <= n_outer_done;
            r_jump_done  <= n_jump_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head  <= n_head;
        r_outer <= n_outer;
        r_prev  <= n_prev;
    end

    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_lower      = r_lower;
        n_remain     = r_remain;
        n_head       = r_head;
        n_outer      = r_outer;
        n_prev       = r_prev;
        n_outer_done = r_outer_done;
        n_jump_done  = r_jump_done;
        store_op     = OP_HOLD;
        push         = 1'b0;
        push_track   = e0;
        push_last    = 1'b0;
        push_jump    = 1'b0;
        case (r_phase)
            PH_LOAD: begin
                if (i_start) begin
                    if (store_ok) begin
                        store_op = OP_INSERT;
                        n_cnt    = r_cnt + 1'b1;
                    end
                    if (i_last_request) begin
                        n_phase  = PH_ROTATE;
                        n_head   = i_start_head;
                        n_outer  = outer_sat;
                        n_prev   = i_start_head;
                        n_lower  = '0;
                        n_remain = store_ok ? r_cnt + 1'b1 : r_cnt;
                    end
                end
            end
            PH_ROTATE: begin
                // move tracks below the head to the tail, drop tracks at the head
                if (r_remain == '0 || e0 > r_head) begin
                    n_phase      = PH_EMIT;
                    n_outer_done = 1'b0;
                    n_jump_done  = 1'b0;
                end else if (e0 < r_head) begin
                    store_op = OP_ROTATE;
                    n_lower  = r_lower + 1'b1;
                    n_remain = r_remain - 1'b1;
                end else begin
                    store_op = OP_SHIFT;
                    n_cnt    = r_cnt - 1'b1;
                    n_remain = r_remain - 1'b1;
                end
            end
            PH_EMIT: begin
                if (!i_q_status.full) begin
                    push = 1'b1;
                    if (!r_outer_done && (!upper_left || r_outer <= e0)) begin
                        push_track   = r_outer;
                        n_outer_done = 1'b1;
                    end else if (upper_left) begin
                        store_op = OP_SHIFT;
                        n_cnt    = r_cnt - 1'b1;
                    end else if (!r_jump_done) begin
                        push_track  = '0;
                        push_jump   = 1'b1;
                        n_jump_done = 1'b1;
                        push_last   = (r_cnt == '0);
                    end else begin
                        // lower sweep: keep the lower count in step with the fill
                        store_op  = OP_SHIFT;
                        n_cnt     = r_cnt - 1'b1;
                        n_lower   = r_lower - 1'b1;
                        push_last = (r_cnt == CNT_W'(1));
                    end
                    n_prev = push_track;
                    if (push_last) begin
                        n_phase = PH_LOAD;
                    end
                end
            end
            default: begin
                n_phase = PH_LOAD;
            end
        endcase
    end

    assign o_busy = (r_phase != PH_LOAD);
    assign o_push = push;
    assign o_item = {push_last, push_dist, push_track};

    a_rotate_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_ROTATE || r_phase == PH_EMIT) |-> (r_lower <= r_cnt))
        else $error("lower count exceeds store fill");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_last) |=> (r_phase == PH_LOAD && r_cnt == '0))
        else $error("store not empty after final visit");

endmodule

>>> hdl/cscan_queue.sv
// cscan_queue: four-entry queue of visit transactions between front and back.
// Depends on cscan_pkg.
module cscan_queue #(
    parameter int WIDTH = 33
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_data,
    output cscan_pkg::t_q_status o_status
);
    import cscan_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;
    logic             do_push, do_pop;

    assign o_status.full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_data         = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PTR_W+1)'(DEPTH))
        else $error("queue count out of range");

endmodule

>>> hdl/cscan_back.sv
// cscan_back: drains visit transactions, accumulates the saturating seek total
// and registers each result for one cycle. Depends on cscan_pkg.
module cscan_back #(
    parameter int TRACK_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [2*TRACK_BITS:0]         i_item,
    input  cscan_pkg::t_q_status          i_status,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [TRACK_BITS-1:0]         o_served_track,
    output logic [cscan_pkg::SEEK_W-1:0]  o_seek_total,
    output logic                          o_final_visit
);
    import cscan_pkg::*;

    localparam int SUM_W = ((TRACK_BITS > SEEK_W) ? TRACK_BITS : SEEK_W) + 1;

    logic [TRACK_BITS-1:0] item_track;
    logic [TRACK_BITS-1:0] item_dist;
    logic                  item_last;
    logic [SUM_W-1:0]      sum_ext;
    logic [SEEK_W-1:0]     sum_sat;

    logic                  r_valid;
    logic [TRACK_BITS-1:0] r_track;
    logic [SEEK_W-1:0]     r_seek;
    logic                  r_final;
    logic [SEEK_W-1:0]     r_sum;

    assign item_track = i_item[TRACK_BITS-1:0];
    assign item_dist  = i_item[2*TRACK_BITS-1:TRACK_BITS];
    assign item_last  = i_item[2*TRACK_BITS];
    assign sum_ext    = SUM_W'(r_sum) + SUM_W'(item_dist);
    assign sum_sat    = (sum_ext > SUM_W'(SEEK_MAX)) ? SEEK_MAX : sum_ext[SEEK_W-1:0];
    assign o_pop      = !i_status.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sum   <= '0;
        end else begin
            r_valid <= o_pop;
            if (o_pop) begin
                r_sum <= item_last ? '0 : sum_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_track <= item_track;
            r_seek  <= sum_sat;
            r_final <= item_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_served_track = r_track;
    assign o_seek_total   = r_seek;
    assign o_final_visit  = r_final;

    a_pop_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> o_valid)
        else $error("popped visit not presented");

    a_seek_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_final && o_pop) |=> (r_seek >= $past(r_seek)))
        else $error("seek total decreased within a schedule");

endmodule

>>> hdl/cscan_disk_request_scheduler.sv
// cscan_disk_request_scheduler: top level of the C-SCAN track request scheduler.
// Holds the configuration registers; depends on cscan_pkg, cscan_front,
// cscan_queue and cscan_back.
//
// Loading: one request transaction per cycle while busy is low; no result.
// Closing: after the flagged request, the front rotates the sorted store past every
// request at or below the start head, then emits one visit per cycle while the queue
// is not full. Results follow one per cycle, n+2 of them for n stored requests
// above or below the head.
// Reset (synchronous, i_rst_n low): empty batch, disk_tracks 1024, start_head 0.
// Results carry no back-pressure: each is valid for exactly one cycle.
module cscan_disk_request_scheduler #(
    parameter int MAX_REQUESTS = 32,
    parameter int TRACK_BITS   = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request transactions
    input  logic                                start,
    output logic                                busy,
    input  logic [TRACK_BITS-1:0]               i_request_track,
    input  logic                                i_last_request,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [cscan_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [TRACK_BITS:0]                 i_cfg_data,
    // result transactions
    output logic                                o_valid,
    output logic [TRACK_BITS-1:0]               o_served_track,
    output logic [cscan_pkg::SEEK_W-1:0]        o_seek_total,
    output logic                                o_final_visit
);
    import cscan_pkg::*;

    localparam int ITEM_W = 2 * TRACK_BITS + 1;
    localparam logic [TRACK_BITS:0] DISK_TRACKS_RST = (TRACK_BITS+1)'(1024);

    logic [TRACK_BITS:0]   r_disk_tracks;
    logic [TRACK_BITS-1:0] r_start_head;

    logic                  q_push;
    logic                  q_pop;
    logic [ITEM_W-1:0]     q_in;
    logic [ITEM_W-1:0]     q_out;
    t_q_status             q_status;

    // Configuration registers: write-only, taken in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_tracks <= DISK_TRACKS_RST;
            r_start_head  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DISK_TRACKS: r_disk_tracks <= i_cfg_data;
                CFG_START_HEAD:  r_start_head  <= i_cfg_data[TRACK_BITS-1:0];
                default:         r_disk_tracks <= r_disk_tracks;
            endcase
        end
    end

    // Front: sort on load, split around the head, push visits in service order
    cscan_front #(
        .MAX_REQUESTS (MAX_REQUESTS),
        .TRACK_BITS   (TRACK_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_request_track (i_request_track),
        .i_last_request  (i_last_request),
        .i_disk_tracks   (r_disk_tracks),
        .i_start_head    (r_start_head),
        .i_q_status      (q_status),
        .o_busy          (busy),
        .o_push          (q_push),
        .o_item          (q_in)
    );

    // Short queue decouples visit generation from seek accumulation
    cscan_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_in),
        .i_pop    (q_pop),
        .o_data   (q_out),
        .o_status (q_status)
    );

    // Back: accumulate saturating seek total and present each result
    cscan_back #(
        .TRACK_BITS (TRACK_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (q_out),
        .i_status       (q_status),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .o_served_track (o_served_track),
        .o_seek_total   (o_seek_total),
        .o_final_visit  (o_final_visit)
    );

    a_busy_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_request) |=> busy)
        else $error("closing transaction did not start scheduling");

endmodule

>>> dv/tb_cscan_disk_request_scheduler.sv
// tb_cscan_disk_request_scheduler: self-checking bench for the C-SCAN track scheduler.
// Drives request batches and register writes, predicts every visit in SystemVerilog.
// Depends on cscan_pkg and cscan_disk_request_scheduler.
`timescale 1ns / 1ps

module tb_cscan_disk_request_scheduler;
    import cscan_pkg::*;

    localparam int MAX_REQ     = 32;
    localparam int TRK_BITS    = 16;
    localparam int TRACK_MAX   = (1 << TRK_BITS) - 1;
    localparam int SETTLE_CYC  = 8;
    localparam int PHASE_ITEMS = 67;

    // One request transaction as the sender sees it
    typedef struct packed {
        logic [TRK_BITS-1:0] track;
        logic                last;
    } t_request;

    // One visit of the schedule
    typedef struct packed {
        logic [TRK_BITS-1:0] track;
        logic [SEEK_W-1:0]   seek;
        logic                last_visit;
    } t_visit;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [TRK_BITS-1:0]   i_request_track = '0;
    logic                  i_last_request  = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx       = CFG_DISK_TRACKS;
    logic [TRK_BITS:0]     i_cfg_data      = '0;
    logic                  o_valid;
    logic [TRK_BITS-1:0]   o_served_track;
    logic [SEEK_W-1:0]     o_seek_total;
    logic                  o_final_visit;

    // Sender side: requests waiting to go on the ports, burst/gap shaping
    t_request request_q[$];
    int       burst_left = 1;
    int       gap_left   = 0;
    logic     steady     = 1'b0;

    // Scheduler shadow: registers, batch store, and visits still owed by the block
    logic [TRK_BITS:0]   cfg_disk_tracks = 17'd1024;
    logic [TRK_BITS-1:0] cfg_start_head  = '0;
    logic [TRK_BITS-1:0] batch_store [0:MAX_REQ-1];
    int                  batch_count     = 0;
    t_visit              owed_visits[$];
    int                  mismatch_count  = 0;

    cscan_disk_request_scheduler #(
        .MAX_REQUESTS (MAX_REQ),
        .TRACK_BITS   (TRK_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_request_track (i_request_track),
        .i_last_request  (i_last_request),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_served_track  (o_served_track),
        .o_seek_total    (o_seek_total),
        .o_final_visit   (o_final_visit)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    function automatic int clip_seek(input int sum);
        return (sum > int'(SEEK_MAX)) ? int'(SEEK_MAX) : sum;
    endfunction

    // Build the C-SCAN order for the stored batch and queue the visits it owes.
    // Sort keys put the upper sweep (outer end included) ahead of the lower
    // sweep (track 0 included); bit TRK_BITS marks the lower group.
    task automatic plan_sweep();
        int   keys [0:MAX_REQ+1];
        int   n, i, j, key, outer, head, pos, trk, seek;
        logic jumped;
        t_visit v;
        head = cfg_start_head;
        if (cfg_disk_tracks == 0)
            outer = 0;
        else if (int'(cfg_disk_tracks) - 1 > TRACK_MAX)
            outer = TRACK_MAX;
        else
            outer = int'(cfg_disk_tracks) - 1;
        keys[0] = outer;
        keys[1] = TRACK_MAX + 1;
        n = 2;
        // Requests on the head track are dropped
        for (i = 0; i < batch_count; i++) begin
            trk = batch_store[i];
            if (trk > head) begin
                keys[n] = trk;
                n++;
            end else if (trk < head) begin
                keys[n] = TRACK_MAX + 1 + trk;
                n++;
            end
        end
        for (i = 1; i < n; i++) begin
            key = keys[i];
            j = i - 1;
            while (j >= 0 && keys[j] > key) begin
                keys[j+1] = keys[j];
                j--;
            end
            keys[j+1] = key;
        end
        seek   = 0;
        pos    = head;
        jumped = 1'b0;
        for (i = 0; i < n; i++) begin
            trk = keys[i] & TRACK_MAX;
            // The return jump counts a full span of seek and lands on track 0
            if (keys[i] > TRACK_MAX && !jumped) begin
                seek   = clip_seek(seek + outer);
                pos    = 0;
                jumped = 1'b1;
            end
            seek = clip_seek(seek + ((trk > pos) ? trk - pos : pos - trk));
            pos  = trk;
            v.track      = trk[TRK_BITS-1:0];
            v.seek       = seek[SEEK_W-1:0];
            v.last_visit = (i == n - 1);
            owed_visits = {owed_visits, v};
        end
    endtask

    // Store one accepted request; the flagged one closes the batch
    task automatic take_request(input logic [TRK_BITS-1:0] trk, input logic last);
        if (batch_count < MAX_REQ) begin
            batch_store[batch_count] = trk;
            batch_count++;
        end
        if (last) begin
            plan_sweep();
            batch_count = 0;
        end
    endtask

    // Driver: hold the current transaction until taken, then present the next
    // one unless a gap is running. Only one NBA per signal per edge.
    always @(posedge i_clk) begin
        t_request req;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (request_q.size() > 0) begin
                req = request_q.pop_front();
                start           <= 1'b1;
                i_request_track <= req.track;
                i_last_request  <= req.last;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    if (steady || $urandom_range(0, 3) == 0)
                        gap_left = 0;
                    else
                        gap_left = $urandom_range(1, 6);
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predict on each accepted request, check each visit strobe.
    // Values are sampled as they stood before the edge.
    always @(posedge i_clk) begin
        t_visit want;
        if (i_rst_n) begin
            if (start && !busy)
                take_request(i_request_track, i_last_request);
            if (o_valid) begin
                if (owed_visits.size() == 0) begin
                    report_mismatch($sformatf("visit to track %0d with none owed",
                                              o_served_track));
                end else begin
                    want = owed_visits.pop_front();
                    if (o_served_track !== want.track)
                        report_mismatch($sformatf("served_track %0d, want %0d",
                                                  o_served_track, want.track));
                    if (o_seek_total !== want.seek)
                        report_mismatch($sformatf("seek_total %0d, want %0d (track %0d)",
                                                  o_seek_total, want.seek, want.track));
                    if (o_final_visit !== want.last_visit)
                        report_mismatch($sformatf("final_visit %0b, want %0b (track %0d)",
                                                  o_final_visit, want.last_visit,
                                                  want.track));
                end
            end
        end
    end

    task automatic push_request(input int trk, input logic last);
        t_request req;
        req.track = trk[TRK_BITS-1:0];
        req.last  = last;
        request_q = {request_q, req};
    endtask

    // Hold until every request is taken, every visit has come and the block is idle,
    // then let it settle before anything touches the registers.
    task automatic settle();
        while (request_q.size() != 0 || start || owed_visits.size() != 0 || busy)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[TRK_BITS:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_DISK_TRACKS)
            cfg_disk_tracks = value[TRK_BITS:0];
        else
            cfg_start_head = value[TRK_BITS-1:0];
    endtask

    task automatic set_disk(input int tracks, input int head);
        write_reg(CFG_DISK_TRACKS, tracks);
        write_reg(CFG_START_HEAD, head);
    endtask

    // Pick a track that lands on interesting spots of the current geometry
    function automatic int pick_track();
        int span;
        span = (cfg_disk_tracks == 0) ? 0 : int'(cfg_disk_tracks) - 1;
        if (span > TRACK_MAX)
            span = TRACK_MAX;
        case ($urandom_range(0, 7))
            0:       return cfg_start_head;
            1:       return 0;
            2:       return TRACK_MAX;
            3:       return span;
            4, 5:    return $urandom_range(0, span);
            default: return $urandom & TRACK_MAX;
        endcase
    endfunction

    // Well-formed batches with random content; now and then one overfills the store
    task automatic random_phase(input int tracks, input int head, input logic no_gaps);
        int queued, n, i;
        set_disk(tracks, head);
        steady = no_gaps;
        queued = 0;
        while (queued < PHASE_ITEMS) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_REQ - 2, MAX_REQ + 8)
                                            : $urandom_range(1, 10);
            for (i = 0; i < n; i++)
                push_request(pick_track(), i == n - 1);
            queued += n;
        end
        settle();
    endtask

    // Watchdog
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: head 0 drops track 0, track 65535 lies past the outer end
        push_request(0, 1'b0);
        push_request(TRACK_MAX, 1'b0);
        push_request(512, 1'b0);
        push_request(512, 1'b0);
        push_request(100, 1'b1);
        settle();

        // Head parked on the outer end: outer end still visited, nothing above
        set_disk(65536, TRACK_MAX);
        push_request(TRACK_MAX, 1'b0);
        push_request(0, 1'b0);
        push_request(32768, 1'b1);
        settle();

        // Zero tracks: outer end collapses to track 0 below the head
        set_disk(0, 300);
        push_request(300, 1'b0);
        push_request(299, 1'b0);
        push_request(301, 1'b1);
        settle();

        // Track count past the range: outer end clips to the top track
        set_disk(131071, 16'h5555);
        push_request(16'hAAAA, 1'b1);
        settle();

        // Single-track disk, lone request on the head: only the end tracks remain
        set_disk(1, 0);
        push_request(0, 1'b1);
        settle();

        random_phase(2, 0, 1'b0);
        random_phase(65536, TRACK_MAX, 1'b1);
        random_phase($urandom_range(2, 65536), $urandom & TRACK_MAX, 1'b0);
        random_phase(131071, $urandom & TRACK_MAX, 1'b0);
        random_phase($urandom_range(0, 1), $urandom & TRACK_MAX, 1'b0);
        random_phase(1024, $urandom_range(0, 1023), 1'b0);

        if (mismatch_count == 0 && owed_visits.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> cscan_disk_request_scheduler.f
hdl/cscan_pkg.sv
hdl/cscan_front.sv
hdl/cscan_queue.sv
hdl/cscan_back.sv
hdl/cscan_disk_request_scheduler.sv
dv/tb_cscan_disk_request_scheduler.sv
